@@ rtl/core/length_prefixed_packet_ring_core_defines.svh @@
// Assertion helpers for the packet ring RTL, used by the control block.
// Every check is sampled on the rising clock edge and is off while reset is high.
`ifndef LENGTH_PREFIXED_PACKET_RING_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_RING_CORE_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define LPPR_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition implies the consequence in the next cycle.
`define LPPR_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/lppr_pkg.sv @@
`timescale 1ns / 1ps

package lppr_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 512;
   localparam int RING_MIN   = 4;

   // Field widths
   localparam int CFG_W    = 10;
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int BLEN_W   = 10;
   localparam int STATUS_W = 3;
   localparam int WORD_W   = 64;
   localparam int BVALID_W = 4;
   localparam int PLEN_W   = 10;
   localparam int LANE_W   = 3;
   localparam int HDR_W    = 16;

   // Stream payload widths
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } lppr_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_PUSH_OK      = 3'd0,
      RSP_PUSH_REFUSED = 3'd1,
      RSP_POP_DATA     = 3'd2,
      RSP_NO_PACKET    = 3'd3,
      RSP_CLEARED      = 3'd4
   } lppr_status_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_POP_HI,
      ST_POP_LEN,
      ST_DRAIN,
      ST_EMIT
   } lppr_state_type;

   typedef struct packed {
      lppr_cmd_type       cmd;
      logic [BYTE_W-1:0]  data_byte;
      logic               block_start;
      logic [BLEN_W-1:0]  block_len;
   } lppr_req_type;

   typedef struct packed {
      lppr_status_type     status;
      logic [WORD_W-1:0]   data_word;
      logic [BVALID_W-1:0] bytes_valid;
      logic [PLEN_W-1:0]   packet_len;
      logic                last;
   } lppr_rsp_type;

endpackage

@@ rtl/core/lppr_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
module lppr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/lppr_rsp_queue.sv @@
`timescale 1ns / 1ps

// Two-entry response queue between the control FSM and the rsp stream.
module lppr_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lppr_pkg::lppr_rsp_type push_data,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lppr_pkg::lppr_rsp_type rsp_data
);

   import lppr_pkg::*;

   lppr_rsp_type entry_ff [2];
   lppr_rsp_type entry_in [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign space     = (cnt_ff != 2'd2);
   assign pop       = rsp_valid && rsp_ready;

   // pointer and fill updates
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_valid) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push_valid, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/core/lppr_ctrl.sv @@
`timescale 1ns / 1ps
`include "length_prefixed_packet_ring_core_defines.svh"

// Ring control: push writes, header fetch, drain with zeroing, clear sweep.
module lppr_ctrl #(
   parameter int DEPTH = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lppr_pkg::lppr_req_type        req,
   input  logic                          csr_valid,
   input  logic [lppr_pkg::CFG_W-1:0]    csr_data,
   output logic                          res_valid,
   output lppr_pkg::lppr_rsp_type        res,
   input  logic                          res_space,
   output logic                          ram_we,
   output logic [$clog2(DEPTH)-1:0]      ram_waddr,
   output logic [lppr_pkg::BYTE_W-1:0]   ram_wdata,
   output logic                          ram_re,
   output logic [$clog2(DEPTH)-1:0]      ram_raddr,
   input  logic [lppr_pkg::BYTE_W-1:0]   ram_rdata
);

   import lppr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   lppr_state_type      state_ff, state_in;
   logic [CFG_W-1:0]    ring_size_ff, ring_size_in;
   logic [AW-1:0]       rd_pos_ff, rd_pos_in;
   logic [AW-1:0]       wr_pos_ff, wr_pos_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [BLEN_W-1:0]   blk_left_ff, blk_left_in;
   logic [AW-1:0]       sweep_ff, sweep_in;
   logic [AW-1:0]       hdr_pos_ff, hdr_pos_in;
   logic [BYTE_W-1:0]   hdr_lo_ff, hdr_lo_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic [PLEN_W-1:0]   left_ff, left_in;
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic                cap_vld_ff, cap_vld_in;
   logic [LANE_W-1:0]   cap_lane_ff, cap_lane_in;
   logic [WORD_W-1:0]   word_ff, word_in;

   logic                req_fire;
   logic [BLEN_W:0]     blk_sum;
   logic                blk_fits;
   logic [BLEN_W-1:0]   new_left;
   logic                do_write;
   logic [HDR_W-1:0]    hdr_len;
   logic                hdr_bad;

   // next position with wraparound at the configured ring size
   function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                             input logic [CFG_W-1:0] size);
      logic [AW:0] nxt;
      nxt = {1'b0, pos} + 1'b1;
      if (CFG_W'(nxt) >= size) begin
         return '0;
      end
      return nxt[AW-1:0];
   endfunction

   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] s;
      s = v;
      if (s < CFG_W'(RING_MIN)) begin
         s = CFG_W'(RING_MIN);
      end
      if (s > CFG_W'(DEPTH)) begin
         s = CFG_W'(DEPTH);
      end
      return s;
   endfunction

   // shared decode
   always_comb begin
      req_ready = (state_ff == ST_IDLE) && res_space;
      req_fire  = req_valid && req_ready;
      blk_sum   = {1'b0, req.block_len} + (BLEN_W + 1)'(count_ff);
      blk_fits  = blk_sum <= {1'b0, ring_size_ff};
      if (req.block_start) begin
         new_left = blk_fits ? req.block_len : '0;
      end else begin
         new_left = blk_left_ff;
      end
      do_write = (new_left != '0);
      hdr_len  = {ram_rdata, hdr_lo_ff};
      hdr_bad  = (hdr_len == '0) || (hdr_len > HDR_W'(count_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_valid) begin
         state_in = ST_SWEEP;
      end else begin
         case (state_ff)
            ST_SWEEP: begin
               if (sweep_ff == AW'(DEPTH - 1)) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  case (req.cmd)
                     CMD_POP:   state_in = ST_POP_HI;
                     CMD_CLEAR: state_in = ST_SWEEP;
                     default:   state_in = ST_IDLE;
                  endcase
               end
            end
            ST_POP_HI: begin
               state_in = ST_POP_LEN;
            end
            ST_POP_LEN: begin
               if (!hdr_bad) begin
                  state_in = ST_DRAIN;
               end else if (res_space) begin
                  state_in = ST_IDLE;
               end
            end
            ST_DRAIN: begin
               if (lane_ff == '1 || left_ff == PLEN_W'(1)) begin
                  state_in = ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (res_space) begin
                  state_in = (left_ff == '0) ? ST_IDLE : ST_DRAIN;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // outputs and datapath
   always_comb begin
      ring_size_in = ring_size_ff;
      rd_pos_in    = rd_pos_ff;
      wr_pos_in    = wr_pos_ff;
      count_in     = count_ff;
      blk_left_in  = blk_left_ff;
      sweep_in     = sweep_ff;
      hdr_pos_in   = hdr_pos_ff;
      hdr_lo_in    = hdr_lo_ff;
      plen_in      = plen_ff;
      left_in      = left_ff;
      lane_in      = lane_ff;
      cap_vld_in   = 1'b0;
      cap_lane_in  = cap_lane_ff;
      word_in      = word_ff;

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;

      res_valid       = 1'b0;
      res.status      = RSP_PUSH_OK;
      res.data_word   = '0;
      res.bytes_valid = '0;
      res.packet_len  = '0;
      res.last        = 1'b1;

      // byte read last cycle lands in its lane
      if (cap_vld_ff) begin
         word_in[{cap_lane_ff, 3'b000} +: BYTE_W] = ram_rdata;
      end

      case (state_ff)
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            sweep_in  = sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req.cmd)
                  CMD_PUSH: begin
                     if (req.block_start) begin
                        res_valid  = 1'b1;
                        res.status = blk_fits ? RSP_PUSH_OK : RSP_PUSH_REFUSED;
                     end
                     blk_left_in = new_left;
                     if (do_write) begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_pos_ff;
                        ram_wdata   = req.data_byte;
                        wr_pos_in   = advance(wr_pos_ff, ring_size_ff);
                        count_in    = count_ff + 1'b1;
                        blk_left_in = new_left - 1'b1;
                     end
                  end
                  CMD_POP: begin
                     ram_re     = 1'b1;
                     ram_raddr  = rd_pos_ff;
                     hdr_pos_in = advance(rd_pos_ff, ring_size_ff);
                  end
                  CMD_CLEAR: begin
                     res_valid   = 1'b1;
                     res.status  = RSP_CLEARED;
                     rd_pos_in   = '0;
                     wr_pos_in   = '0;
                     count_in    = '0;
                     blk_left_in = '0;
                     sweep_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_HI: begin
            ram_re    = 1'b1;
            ram_raddr = hdr_pos_ff;
            hdr_lo_in = ram_rdata;
         end
         ST_POP_LEN: begin
            if (hdr_bad) begin
               res_valid  = res_space;
               res.status = RSP_NO_PACKET;
            end else begin
               plen_in = hdr_len[PLEN_W-1:0];
               left_in = hdr_len[PLEN_W-1:0];
               word_in = '0;
               lane_in = '0;
            end
         end
         ST_DRAIN: begin
            // read one byte and zero its entry in the same cycle
            ram_re      = 1'b1;
            ram_raddr   = rd_pos_ff;
            ram_we      = 1'b1;
            ram_waddr   = rd_pos_ff;
            rd_pos_in   = advance(rd_pos_ff, ring_size_ff);
            left_in     = left_ff - 1'b1;
            cap_vld_in  = 1'b1;
            cap_lane_in = lane_ff;
            lane_in     = lane_ff + 1'b1;
         end
         ST_EMIT: begin
            res.status      = RSP_POP_DATA;
            res.data_word   = word_in;
            res.bytes_valid = BVALID_W'(cap_lane_ff) + 1'b1;
            res.packet_len  = plen_ff;
            res.last        = (left_ff == '0);
            if (res_space) begin
               res_valid = 1'b1;
               word_in   = '0;
               lane_in   = '0;
               if (left_ff == '0) begin
                  count_in = count_ff - CW'(plen_ff);
               end
            end
         end
         default: begin
         end
      endcase

      // register write empties the ring and restarts the sweep
      if (csr_valid) begin
         ring_size_in = clamp_size(csr_data);
         rd_pos_in    = '0;
         wr_pos_in    = '0;
         count_in     = '0;
         blk_left_in  = '0;
         sweep_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ring_size_ff <= clamp_size(CFG_W'(RING_DEPTH));
         rd_pos_ff    <= '0;
         wr_pos_ff    <= '0;
         count_ff     <= '0;
         blk_left_ff  <= '0;
         sweep_ff     <= '0;
         cap_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_size_ff <= ring_size_in;
         rd_pos_ff    <= rd_pos_in;
         wr_pos_ff    <= wr_pos_in;
         count_ff     <= count_in;
         blk_left_ff  <= blk_left_in;
         sweep_ff     <= sweep_in;
         cap_vld_ff   <= cap_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      hdr_pos_ff  <= hdr_pos_in;
      hdr_lo_ff   <= hdr_lo_in;
      plen_ff     <= plen_in;
      left_ff     <= left_in;
      lane_ff     <= lane_in;
      cap_lane_ff <= cap_lane_in;
      word_ff     <= word_in;
   end

   // checks
   `LPPR_CHECK_NOW(a_count_in_ring, 1'b1, CFG_W'(count_ff) <= ring_size_ff, "count above ring size")
   `LPPR_CHECK_NOW(a_pos_in_ring, 1'b1, (CFG_W'(rd_pos_ff) < ring_size_ff) && (CFG_W'(wr_pos_ff) < ring_size_ff), "position outside ring")
   `LPPR_CHECK_NOW(a_res_has_room, res_valid, res_space, "response pushed into full queue")
   `LPPR_CHECK_NEXT(a_pop_releases, (state_ff == ST_EMIT) && (state_in == ST_IDLE), count_ff == $past(count_ff) - CW'($past(plen_ff)), "pop did not release packet bytes")

endmodule

@@ rtl/core/length_prefixed_packet_ring_core.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Contents
// req_*    in   tdata {block_len, data_byte}, tuser {block_start, cmd}
// rsp_*    out  tdata {packet_len, bytes_valid, data_word}, tuser status, tlast
// csr_*    in   ring_size write, always ready
//
// Requests are taken in IDLE while the response queue has room: push, clear command and
// no-op are handled there, and a push streams one byte per cycle while that holds. Pop:
// the header is fetched in IDLE and POP_HI and checked in POP_LEN, then each result of
// n <= 8 bytes is read byte by byte on the RAM read port in DRAIN and sent in EMIT.
// Reset, clear command and ring_size writes start a zeroing sweep of all DEPTH entries
// through the write port, taking no requests; a two-entry queue decouples rsp_tready.
module length_prefixed_packet_ring_core #(
   parameter int DEPTH = lppr_pkg::RING_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: data_byte [7:0], block_len [17:8], zero fill
   // req_tuser: cmd [1:0], block_start [2]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lppr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [lppr_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // rsp_tdata: data_word [63:0], bytes_valid [67:64], packet_len [77:68], zero fill
   // rsp_tuser: status [2:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lppr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [lppr_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lppr_pkg::CFG_W-1:0]         csr_wdata
);

   import lppr_pkg::*;

   localparam int AW = $clog2(DEPTH);

   lppr_req_type      req;
   lppr_rsp_type      res;
   lppr_rsp_type      rsp;
   logic              res_valid;
   logic              res_space;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   // request unpack
   always_comb begin
      req.cmd         = lppr_cmd_type'(req_tuser[CMD_W-1:0]);
      req.block_start = req_tuser[CMD_W];
      req.data_byte   = req_tdata[BYTE_W-1:0];
      req.block_len   = req_tdata[BYTE_W +: BLEN_W];
   end

   assign csr_ready = 1'b1;

   lppr_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_data  (csr_wdata),
      .res_valid (res_valid),
      .res       (res),
      .res_space (res_space),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   lppr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lppr_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .space      (res_space),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp)
   );

   // response pack
   assign rsp_tdata = {(RSP_TDATA_W - WORD_W - BVALID_W - PLEN_W)'(0),
                       rsp.packet_len, rsp.bytes_valid, rsp.data_word};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule

@@ dv/tb_length_prefixed_packet_ring_core.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_packet_ring_core;
   import lppr_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // data_byte [7:0], block_len [17:8], zero fill
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // cmd [1:0], block_start [2]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // data_word [63:0], bytes_valid [67:64], packet_len [77:68], zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status [2:0]
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_wdata = '0;

   length_prefixed_packet_ring_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ring shadow: store, pointers, fill level and open block
   int unsigned   ring_sz = RING_DEPTH;
   logic [7:0]    ring_bytes [RING_DEPTH];
   int unsigned   rd_ptr, wr_ptr, fill, blk_left;
   bit            blk_open;
   lppr_rsp_type  rsp_expected [$];

   // Stimulus side
   lppr_req_type  req_pending [$];
   lppr_req_type  cur_req;
   bit            req_fire = 1'b0;
   int unsigned   gap_left = 0, burst_left = 0;
   int unsigned   gen_items = 0, gen_events = 0;

   // Run statistics
   int unsigned   req_count = 0, rsp_count = 0, cfg_count = 0, fail_count = 0;

   function automatic int unsigned clamp_ring(logic [CFG_W-1:0] v);
      if (v < RING_MIN) return RING_MIN;
      if (v > RING_DEPTH) return RING_DEPTH;
      return v;
   endfunction

   function automatic int unsigned next_pos(int unsigned p);
      return (p + 1 >= ring_sz) ? 0 : p + 1;
   endfunction

   function automatic void wipe_ring();
      foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
      rd_ptr   = 0;
      wr_ptr   = 0;
      fill     = 0;
      blk_open = 1'b0;
      blk_left = 0;
   endfunction

   function automatic void add_expect(lppr_status_type st, logic [WORD_W-1:0] w,
                                      int unsigned nb, int unsigned pl, bit lst);
      lppr_rsp_type e;
      e.status      = st;
      e.data_word   = w;
      e.bytes_valid = BVALID_W'(nb);
      e.packet_len  = PLEN_W'(pl);
      e.last        = lst;
      rsp_expected.push_back(e);
   endfunction

   // Update the shadow ring for one accepted request and queue its responses
   function automatic void predict_ring_request(lppr_req_type r);
      logic [HDR_W-1:0]  hdr;
      logic [WORD_W-1:0] word;
      int unsigned       left, take;
      case (r.cmd)
         CMD_PUSH: begin
            if (r.block_start) begin
               // block is refused whole if it cannot fit
               if (r.block_len + fill > ring_sz) begin
                  blk_open = 1'b0;
                  blk_left = 0;
                  add_expect(RSP_PUSH_REFUSED, '0, 0, 0, 1'b1);
                  return;
               end
               blk_left = r.block_len;
               blk_open = (r.block_len != 0);
               add_expect(RSP_PUSH_OK, '0, 0, 0, 1'b1);
            end
            if (blk_open && blk_left != 0) begin
               ring_bytes[wr_ptr] = r.data_byte;
               wr_ptr = next_pos(wr_ptr);
               fill++;
               blk_left--;
               if (blk_left == 0) blk_open = 1'b0;
            end
         end
         CMD_POP: begin
            hdr = {ring_bytes[next_pos(rd_ptr)], ring_bytes[rd_ptr]};
            if (hdr == 0 || hdr > fill) begin
               add_expect(RSP_NO_PACKET, '0, 0, 0, 1'b1);
               return;
            end
            // emit up to eight bytes per response, zeroing what is read
            left = hdr;
            while (left != 0) begin
               take = (left < 8) ? left : 8;
               word = '0;
               for (int unsigned i = 0; i < take; i++) begin
                  word[8*i +: 8] = ring_bytes[rd_ptr];
                  ring_bytes[rd_ptr] = 8'h00;
                  rd_ptr = next_pos(rd_ptr);
               end
               left -= take;
               add_expect(RSP_POP_DATA, word, take, hdr, left == 0);
            end
            fill -= hdr;
         end
         CMD_CLEAR: begin
            wipe_ring();
            add_expect(RSP_CLEARED, '0, 0, 0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Stimulus builders
   function automatic void queue_req(lppr_cmd_type c, logic [7:0] d, bit s, logic [9:0] l);
      lppr_req_type r;
      r.cmd         = c;
      r.data_byte   = d;
      r.block_start = s;
      r.block_len   = l;
      req_pending.push_back(r);
      if (c != CMD_NOP) gen_items++;
      if ((c == CMD_PUSH && s) || c == CMD_POP || c == CMD_CLEAR) gen_events++;
   endfunction

   // Push block announced as blen; nbytes sent; good_hdr puts blen in the first two bytes
   function automatic void queue_block(int unsigned blen, int unsigned nbytes, bit good_hdr);
      logic [7:0] b;
      for (int unsigned i = 0; i < nbytes; i++) begin
         b = 8'($urandom);
         if (good_hdr && i == 0) b = blen[7:0];
         if (good_hdr && i == 1) b = blen[15:8];
         queue_req(CMD_PUSH, b, i == 0, (i == 0) ? blen[9:0] : 10'($urandom));
      end
   endfunction

   function automatic void random_traffic(int unsigned ring, int unsigned n_items,
                                          int unsigned n_events);
      int unsigned item0, event0, cap, big, len, pick;
      item0  = gen_items;
      event0 = gen_events;
      cap    = (ring < 24) ? ring : 24;
      big    = (ring < 40) ? ring : 40;
      while (gen_items - item0 < n_items || gen_events - event0 < n_events) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // well-formed packet, now and then a longer one
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(2, big)
                                                : $urandom_range(2, cap);
            queue_block(len, len, 1'b1);
         end else if (pick < 72) begin
            queue_req(CMD_POP, 8'($urandom), 1'($urandom), 10'($urandom));
         end else if (pick < 78) begin
            queue_req(CMD_CLEAR, 8'($urandom), 1'($urandom), 10'($urandom));
         end else if (pick < 83) begin
            // block cut short by whatever comes next
            len = $urandom_range(3, cap);
            queue_block(len, $urandom_range(1, len - 1), 1'b1);
         end else if (pick < 87) begin
            // bytes past the announced length
            len = $urandom_range(2, cap);
            queue_block(len, len + $urandom_range(1, 3), 1'b1);
         end else if (pick < 89) begin
            len = $urandom_range(2, cap);
            queue_block(len, len, 1'b0);
         end else if (pick < 92) begin
            queue_req(CMD_PUSH, 8'($urandom), 1'b1, 10'($urandom_range(ring + 1, 1023)));
         end else if (pick < 96) begin
            queue_req(CMD_PUSH, 8'($urandom), 1'b0, 10'($urandom));
         end else begin
            queue_req(CMD_NOP, 8'($urandom), 1'($urandom), 10'($urandom));
         end
      end
   endfunction

   // Wait for every request to go in and every response to come out
   task automatic settle();
      while (req_pending.size() != 0 || req_tvalid || rsp_expected.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_ring_size(logic [CFG_W-1:0] v);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request driver: bursts with random gaps
   always @(negedge clock) begin : req_driver
      if (!reset && (!req_tvalid || req_fire)) begin
         if (gap_left != 0 || req_pending.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            cur_req = req_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {6'd0, cur_req.block_len, cur_req.data_byte};
            req_tuser  <= {cur_req.block_start, cur_req.cmd};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Response ready pattern, with one long hold-off to back the core up
   always @(negedge clock) begin : rsp_stall
      int unsigned rx_cycle, hold_left;
      bit          hold_done, rdy;
      rx_cycle++;
      if (!hold_done && req_count >= 20) begin
         hold_done = 1'b1;
         hold_left = 300;
      end
      if (hold_left != 0) begin
         hold_left--;
         rdy = 1'b0;
      end else begin
         case (rx_cycle[7:6])
            2'd0: rdy = 1'b1;
            2'd1: rdy = 1'($urandom_range(0, 1));
            2'd2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = rx_cycle[0];
         endcase
      end
      rsp_tready <= rdy;
   end

   // Monitor: config and request handshakes feed the shadow, responses are checked
   always @(posedge clock) begin : rsp_monitor
      lppr_rsp_type        want;
      logic [STATUS_W-1:0] got_status;
      logic [WORD_W-1:0]   got_word;
      logic [BVALID_W-1:0] got_nb;
      logic [PLEN_W-1:0]   got_len;
      logic                got_last;
      req_fire = 1'b0;
      if (reset) begin
         ring_sz = RING_DEPTH;
         wipe_ring();
      end else begin
         if (csr_valid && csr_ready) begin
            ring_sz = clamp_ring(csr_wdata);
            wipe_ring();
            cfg_count++;
         end
         if (req_tvalid && req_tready) begin
            req_fire = 1'b1;
            req_count++;
            predict_ring_request(cur_req);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got_status = rsp_tuser[STATUS_W-1:0];
            got_word   = rsp_tdata[63:0];
            got_nb     = rsp_tdata[67:64];
            got_len    = rsp_tdata[77:68];
            got_last   = rsp_tlast;
            if (rsp_expected.size() == 0) begin
               $error("unexpected response: status %0d", got_status);
               fail_count++;
            end else begin
               want = rsp_expected.pop_front();
               if (got_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got_status);
                  fail_count++;
               end
               if (got_word !== want.data_word) begin
                  $error("data_word: expected %h, got %h", want.data_word, got_word);
                  fail_count++;
               end
               if (got_nb !== want.bytes_valid) begin
                  $error("bytes_valid: expected %0d, got %0d", want.bytes_valid, got_nb);
                  fail_count++;
               end
               if (got_len !== want.packet_len) begin
                  $error("packet_len: expected %0d, got %0d", want.packet_len, got_len);
                  fail_count++;
               end
               if (got_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got_last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Main sequence
   initial begin : main_seq
      logic [CFG_W-1:0] ring_settings [7];
      ring_settings = '{10'd4, 10'd0, 10'd1023, 10'd37, 10'd600, 10'd3, 10'd100};

      // directed cases on the reset-size ring
      queue_req(CMD_POP, 8'hFF, 1'b1, 10'h3FF);    // pop from an empty ring
      queue_req(CMD_PUSH, 8'hFF, 1'b1, 10'd0);     // zero-length block
      queue_req(CMD_PUSH, 8'hA5, 1'b0, 10'h3FF);   // stray byte, no block open
      queue_req(CMD_PUSH, 8'h00, 1'b1, 10'h3FF);   // too long, refused
      queue_block(9, 10, 1'b1);                    // one byte past the end is dropped
      queue_req(CMD_POP, 8'h00, 1'b0, 10'd0);      // two responses
      queue_block(2, 2, 1'b1);                     // header-only packet
      queue_req(CMD_POP, 8'h00, 1'b0, 10'd0);
      queue_req(CMD_NOP, 8'hFF, 1'b1, 10'h3FF);
      queue_block(6, 3, 1'b1);                     // abandoned by the next block start
      queue_block(4, 4, 1'b1);
      queue_req(CMD_POP, 8'h00, 1'b0, 10'd0);
      queue_req(CMD_CLEAR, 8'h00, 1'b0, 10'd0);
      // header of zero
      queue_req(CMD_PUSH, 8'h00, 1'b1, 10'd3);
      queue_req(CMD_PUSH, 8'h00, 1'b0, 10'd0);
      queue_req(CMD_PUSH, 8'h55, 1'b0, 10'd0);
      queue_req(CMD_POP, 8'h00, 1'b0, 10'd0);
      queue_req(CMD_CLEAR, 8'h00, 1'b0, 10'd0);
      // header longer than what is stored
      queue_req(CMD_PUSH, 8'hFF, 1'b1, 10'd3);
      queue_req(CMD_PUSH, 8'h00, 1'b0, 10'd0);
      queue_req(CMD_PUSH, 8'h11, 1'b0, 10'd0);
      queue_req(CMD_POP, 8'h00, 1'b0, 10'd0);
      queue_req(CMD_CLEAR, 8'h00, 1'b0, 10'd0);

      random_traffic(RING_DEPTH, 12, 2);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain completely once mid-run, then keep going
      settle();
      random_traffic(RING_DEPTH, 12, 2);

      foreach (ring_settings[i]) begin
         write_ring_size(ring_settings[i]);
         if (ring_settings[i] == 10'd37) begin
            // packet that fills the whole ring
            queue_block(37, 37, 1'b1);
            queue_req(CMD_POP, 8'h00, 1'b0, 10'd0);
         end
         random_traffic(clamp_ring(ring_settings[i]), 12, 2);
      end

      settle();
      repeat (30) @(posedge clock);
      $display("summary: %0d requests, %0d responses checked over %0d ring size writes",
               req_count, rsp_count, cfg_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
